// ===== src/bjt_pkg.sv =====
// ----------------------------------------------------------------------------
// bjt_pkg
// Shared types and constants of the block jump table: the command word from
// the controller to the datapath and the status word that comes back.
// ----------------------------------------------------------------------------
package bjt_pkg;

    localparam int OP_W   = 1;
    localparam int POS_W  = 10;
    localparam int POW_W  = 11;
    localparam int CNT_W  = 11;

    localparam logic [OP_W-1:0]  OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0]  OP_QUERY = 1'b1;

    localparam logic [CNT_W-1:0] HOLE_COUNT_RESET = 11'd1024;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,        // capture the input word, start the walk at position
        CMD_CFG_INIT,    // start a rebuild of every block at block zero
        CMD_WR_POWER,    // store the new distance
        CMD_FIND_STEP,   // move the block start one block forward
        CMD_BLOCK_INIT,  // set the block end and the last cell of the block
        CMD_RD_POWER,    // read the distance of the current cell
        CMD_RD_TARGET,   // form the jump target and read its table entry
        CMD_WR_CELL,     // write the table entry of the current cell
        CMD_NEXT_BLOCK,  // move to the next block of a full rebuild
        CMD_RD_WALK,     // read the table entry at the walk position
        CMD_ACC_WALK,    // add the block count and follow the block exit
        CMD_RD_STEP,     // read the distance of the last cell
        CMD_ACC_STEP,    // single jump inside the last block
        CMD_OUT          // load the result register
    } bjt_cmd_t;

    typedef struct packed {
        logic pos_bad;    // captured position is not below the cell count
        logic is_query;   // captured word is a query
        logic find_done;  // block start reached the block of the position
        logic at_first;   // current cell is the first of its block
        logic blk_past;   // block start lies past the cells in use
        logic walk_exit;  // block exit just read leaves the row
        logic step_exit;  // next single jump leaves the row
    } bjt_status_t;

endpackage

// ===== src/bjt_datapath.sv =====
// ----------------------------------------------------------------------------
// bjt_datapath
// Distance and jump-table memories, the cell count register, the walk and
// rebuild registers and the result register.
// ----------------------------------------------------------------------------
module bjt_datapath
    import bjt_pkg::*;
#(
    parameter int NUM_CELLS  = 1024,
    parameter int BLOCK_SIZE = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic [OP_W-1:0]   operation,
    input  logic [POS_W-1:0]  position,
    input  logic [POW_W-1:0]  power,
    input  bjt_cmd_t          cmd,
    output bjt_status_t       stat,
    output logic [POS_W-1:0]  last_cell,
    output logic [CNT_W-1:0]  jump_count,
    output logic              status
);

    localparam int AW = $clog2(NUM_CELLS);
    localparam int XW = $clog2(NUM_CELLS + 2048);
    localparam int JW = $clog2(BLOCK_SIZE + 1);

    logic [POW_W-1:0] power_mem [NUM_CELLS];
    logic [XW-1:0]    exit_mem  [NUM_CELLS];
    logic [JW-1:0]    jumps_mem [NUM_CELLS];

    logic [CNT_W-1:0] hole_reg;
    logic [OP_W-1:0]  op_reg;
    logic [XW-1:0]    pos_reg;
    logic [POW_W-1:0] pw_in_reg;
    logic [XW-1:0]    first_reg;
    logic [XW-1:0]    stop_reg;
    logic [XW-1:0]    c_reg;
    logic [XW-1:0]    target_reg;
    logic [XW-1:0]    a_reg;
    logic [XW-1:0]    last_reg;
    logic [XW-1:0]    total_reg;
    logic [POW_W-1:0] pw_q;
    logic [XW-1:0]    ex_q;
    logic [JW-1:0]    jq;
    logic [POS_W-1:0] res_last_reg;
    logic [CNT_W-1:0] res_count_reg;
    logic             res_status_reg;

    logic [XW-1:0]    n;
    logic [XW-1:0]    hop;
    logic [XW-1:0]    nxt;
    logic [XW-1:0]    tgt;
    logic [XW-1:0]    blk_end;
    logic [XW-1:0]    exit_wr;
    logic [JW-1:0]    jumps_wr;
    logic [AW-1:0]    pw_addr;
    logic [AW-1:0]    tab_addr;

    always_comb
    begin
        n        = ({{(XW-CNT_W){1'b0}}, hole_reg} > XW'(NUM_CELLS)) ?
                   XW'(NUM_CELLS) : {{(XW-CNT_W){1'b0}}, hole_reg};
        hop      = (pw_q == '0) ? XW'(1) : {{(XW-POW_W){1'b0}}, pw_q};
        nxt      = last_reg + hop;
        tgt      = c_reg + hop;
        blk_end  = first_reg + XW'(BLOCK_SIZE);
        // A jump that leaves the block ends the entry; past the row it saturates.
        if (target_reg >= stop_reg)
        begin
            exit_wr  = (target_reg > n) ? n : target_reg;
            jumps_wr = JW'(1);
        end
        else
        begin
            exit_wr  = ex_q;
            jumps_wr = jq + JW'(1);
        end
        pw_addr  = (cmd == CMD_RD_STEP) ? last_reg[AW-1:0] : c_reg[AW-1:0];
        tab_addr = (cmd == CMD_RD_WALK) ? a_reg[AW-1:0] : tgt[AW-1:0];
    end

    always_comb
    begin
        stat.pos_bad   = pos_reg >= n;
        stat.is_query  = op_reg == OP_QUERY;
        stat.find_done = blk_end > pos_reg;
        stat.at_first  = c_reg == first_reg;
        stat.blk_past  = first_reg >= n;
        stat.walk_exit = ex_q >= n;
        stat.step_exit = nxt >= n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hole_reg <= HOLE_COUNT_RESET;
        else if (cfg_wr_en)
            hole_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_WR_POWER)
            power_mem[pos_reg[AW-1:0]] <= pw_in_reg;
        if (cmd == CMD_RD_POWER || cmd == CMD_RD_STEP)
            pw_q <= power_mem[pw_addr];
    end

    // The step to the next block of a full rebuild also writes the first cell.
    always_ff @(posedge clk)
    begin
        if (cmd == CMD_WR_CELL || cmd == CMD_NEXT_BLOCK)
        begin
            exit_mem[c_reg[AW-1:0]]  <= exit_wr;
            jumps_mem[c_reg[AW-1:0]] <= jumps_wr;
        end
        if (cmd == CMD_RD_WALK || cmd == CMD_RD_TARGET)
        begin
            ex_q <= exit_mem[tab_addr];
            jq   <= jumps_mem[tab_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                op_reg    <= operation;
                pos_reg   <= {{(XW-POS_W){1'b0}}, position};
                pw_in_reg <= power;
                a_reg     <= {{(XW-POS_W){1'b0}}, position};
                last_reg  <= {{(XW-POS_W){1'b0}}, position};
                total_reg <= '0;
                first_reg <= '0;
            end
            CMD_CFG_INIT:
                first_reg <= '0;
            CMD_FIND_STEP, CMD_NEXT_BLOCK:
                first_reg <= blk_end;
            CMD_BLOCK_INIT:
            begin
                stop_reg <= (blk_end > n) ? n : blk_end;
                c_reg    <= ((blk_end > n) ? n : blk_end) - XW'(1);
            end
            CMD_RD_TARGET:
                target_reg <= tgt;
            CMD_WR_CELL:
                c_reg <= c_reg - XW'(1);
            CMD_ACC_WALK:
            begin
                total_reg <= total_reg + {{(XW-JW){1'b0}}, jq};
                last_reg  <= a_reg;
                a_reg     <= ex_q;
            end
            CMD_ACC_STEP:
                if (!stat.step_exit)
                    last_reg <= nxt;
            CMD_OUT:
                if (stat.pos_bad)
                begin
                    res_last_reg   <= '0;
                    res_count_reg  <= '0;
                    res_status_reg <= STATUS_ERR;
                end
                else
                begin
                    res_last_reg   <= last_reg[POS_W-1:0];
                    res_count_reg  <= total_reg[CNT_W-1:0];
                    res_status_reg <= STATUS_OK;
                end
            default:
            begin
            end
        endcase
    end

    assign last_cell  = res_last_reg;
    assign jump_count = res_count_reg;
    assign status     = res_status_reg;

endmodule

// ===== src/bjt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bjt_ctrl
// Sequencer of the block jump table: accepts words, steps the datapath
// through updates, table rebuilds and walks, and holds the result valid.
// ----------------------------------------------------------------------------
module bjt_ctrl
    import bjt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  bjt_status_t stat,
    output bjt_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FIND,
        S_BLK_CHECK,
        S_BLK_INIT,
        S_RD_P,
        S_RD_T,
        S_WR_C,
        S_RD_W,
        S_ACC_W,
        S_RD_S,
        S_ACC_S,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   all_reg, all_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || cfg_wr_en;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        all_next       = all_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
                if (cfg_wr_en)
                begin
                    cmd        = CMD_CFG_INIT;
                    all_next   = 1'b1;
                    state_next = S_BLK_CHECK;
                end
                else if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    all_next   = 1'b0;
                    state_next = S_CHECK;
                end
            S_CHECK:
                if (stat.pos_bad)
                    state_next = S_OUT;
                else if (stat.is_query)
                    state_next = S_RD_W;
                else
                begin
                    cmd        = CMD_WR_POWER;
                    state_next = S_FIND;
                end
            S_FIND:
                if (stat.find_done)
                    state_next = S_BLK_INIT;
                else
                    cmd = CMD_FIND_STEP;
            S_BLK_CHECK:
                state_next = stat.blk_past ? S_IDLE : S_BLK_INIT;
            S_BLK_INIT:
            begin
                cmd        = CMD_BLOCK_INIT;
                state_next = S_RD_P;
            end
            S_RD_P:
            begin
                cmd        = CMD_RD_POWER;
                state_next = S_RD_T;
            end
            S_RD_T:
            begin
                cmd        = CMD_RD_TARGET;
                state_next = S_WR_C;
            end
            S_WR_C:
            begin
                cmd = CMD_WR_CELL;
                if (!stat.at_first)
                    state_next = S_RD_P;
                else if (all_reg)
                begin
                    // A full rebuild moves to the next block with the first cell.
                    cmd        = CMD_NEXT_BLOCK;
                    state_next = S_BLK_CHECK;
                end
                else
                    state_next = S_IDLE;
            end
            S_RD_W:
            begin
                cmd        = CMD_RD_WALK;
                state_next = S_ACC_W;
            end
            S_ACC_W:
            begin
                cmd        = CMD_ACC_WALK;
                state_next = stat.walk_exit ? S_RD_S : S_RD_W;
            end
            S_RD_S:
            begin
                cmd        = CMD_RD_STEP;
                state_next = S_ACC_S;
            end
            S_ACC_S:
            begin
                cmd        = CMD_ACC_STEP;
                state_next = stat.step_exit ? S_OUT : S_RD_S;
            end
            S_OUT:
                if (slot_free)
                begin
                    cmd            = CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            all_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            all_reg       <= all_next;
        end
    end

endmodule

// ===== src/block_jump_table.sv =====
// ----------------------------------------------------------------------------
// block_jump_table
// Jump-pointer table over a row of cells kept in fixed blocks.
// ----------------------------------------------------------------------------
// Each word either writes one cell's jump distance (operation 0) or walks
// from a cell (operation 1) and returns the last cell visited and the number
// of jumps. One word is worked on at a time, through single-port memories.
// A query follows the block exits to the last block, then single jumps
// inside it. An update steps the block start to the block of the written
// cell and rebuilds that block from its last cell down. A write of the cell
// count while idle rebuilds every block, and no word is taken meanwhile.
// Results are defined only once every cell in use has been written. A
// result word waits in an output register while the next word is taken.
// ----------------------------------------------------------------------------
module block_jump_table
    import bjt_pkg::*;
#(
    parameter int NUM_CELLS  = 1024,
    parameter int BLOCK_SIZE = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [POS_W-1:0]  position,
    input  logic [POW_W-1:0]  power,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [POS_W-1:0]  last_cell,
    output logic [CNT_W-1:0]  jump_count,
    output logic              status
);

    bjt_cmd_t    cmd;
    bjt_status_t stat;

    bjt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bjt_datapath #(
        .NUM_CELLS  (NUM_CELLS),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .operation   (operation),
        .position    (position),
        .power       (power),
        .cmd         (cmd),
        .stat        (stat),
        .last_cell   (last_cell),
        .jump_count  (jump_count),
        .status      (status)
    );

endmodule

// ===== tb/block_jump_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_jump_table_tb
// Self-checking bench: random and directed writes and walks, checked against
// a behavioral jump table kept inside the bench.
// ----------------------------------------------------------------------------
// Every cell in use is written before the first walk. The cell count is
// changed only while the block is idle. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module block_jump_table_tb
    import bjt_pkg::*;
;

    localparam int CELLS    = 1024;
    localparam int BLK      = 32;
    localparam int IDLE_PCT = 28;
    localparam int WD_LIMIT = 20000;
    localparam int SETTLE   = 300;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [POW_W-1:0] pw;
    } cmd_word_t;

    typedef struct packed {
        logic [POS_W-1:0] cell_no;
        logic [CNT_W-1:0] cnt;
        logic             st;
    } walk_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [POW_W-1:0] power;
    logic             out_valid;
    logic             out_stall;
    logic [POS_W-1:0] last_cell;
    logic [CNT_W-1:0] jump_count;
    logic             status;

    cmd_word_t    pending_words[$];
    walk_result_t expected_walks[$];

    // Shadow state of the jump table.
    int unsigned  model_holes;
    int unsigned  dist_mem[CELLS];
    int unsigned  exit_mem[CELLS];
    int unsigned  hops_mem[CELLS];

    int  errors;
    int  quiet_cycles;
    bit  calm;
    bit  took;

    block_jump_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .position    (position),
        .power       (power),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .last_cell   (last_cell),
        .jump_count  (jump_count),
        .status      (status)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int unsigned live_cells();
        return (model_holes > CELLS) ? CELLS : model_holes;
    endfunction

    function automatic int unsigned hop_of(int unsigned c);
        return (dist_mem[c] == 0) ? 1 : dist_mem[c];
    endfunction

    function automatic void rebuild_segment(int unsigned b);
        int unsigned n;
        int unsigned first;
        int unsigned stop;
        int unsigned t;
        n     = live_cells();
        first = b * BLK;
        if (first >= n)
            return;
        stop = (first + BLK > n) ? n : first + BLK;
        for (int c = stop - 1; c >= int'(first); c--)
        begin
            t = c + hop_of(c);
            if (t >= stop)
            begin
                exit_mem[c] = (t > n) ? n : t;
                hops_mem[c] = 1;
            end
            else
            begin
                exit_mem[c] = exit_mem[t];
                hops_mem[c] = hops_mem[t] + 1;
            end
        end
    endfunction

    task automatic set_hole_count(int unsigned v);
        model_holes = v & 11'h7FF;
        for (int b = 0; b < CELLS / BLK; b++)
            rebuild_segment(b);
    endtask

    // Apply one accepted word to the shadow table; returns 1 with a result.
    function automatic bit apply_word(cmd_word_t w, output walk_result_t r);
        int unsigned n;
        int unsigned a;
        int unsigned total;
        int unsigned last;
        n = live_cells();
        r = '0;
        if (w.pos >= n)
        begin
            r.st = STATUS_ERR;
            return 1'b1;
        end
        if (w.op == OP_WRITE)
        begin
            dist_mem[w.pos] = w.pw;
            rebuild_segment(w.pos / BLK);
            return 1'b0;
        end
        a     = w.pos;
        total = 0;
        last  = w.pos;
        while (a < n)
        begin
            total += hops_mem[a];
            last  = a;
            a     = exit_mem[a];
        end
        for (int unsigned i = last; i < n; i += hop_of(i))
            last = i;
        r.cell_no = last[POS_W-1:0];
        r.cnt     = total[CNT_W-1:0];
        r.st      = STATUS_OK;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    // Driver: a new word goes out at the falling edge once the last one is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            if (!in_valid || took)
            begin
                if (pending_words.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    operation <= pending_words[0].op;
                    position  <= pending_words[0].pos;
                    power     <= pending_words[0].pw;
                    void'(pending_words.pop_front());
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on accepted input words, checks accepted results.
    always @(posedge clk)
    begin
        walk_result_t got;
        walk_result_t want;
        cmd_word_t    w;
        if (rst_n)
        begin
            took <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                got = '{last_cell, jump_count, status};
                if (expected_walks.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = expected_walks.pop_front();
                    if (got.st !== want.st)
                        report_mismatch($sformatf("status %b, expected %b", got.st, want.st));
                    if (got.cell_no !== want.cell_no)
                        report_mismatch($sformatf("last_cell %0d, expected %0d",
                                                  got.cell_no, want.cell_no));
                    if (got.cnt !== want.cnt)
                        report_mismatch($sformatf("jump_count %0d, expected %0d",
                                                  got.cnt, want.cnt));
                end
            end
            if (in_valid && !in_stall)
            begin
                w = '{operation, position, power};
                if (apply_word(w, want))
                    expected_walks.push_back(want);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_word(logic [OP_W-1:0] op, int unsigned pos, int unsigned pw);
        pending_words.push_back('{op, pos[POS_W-1:0], pw[POW_W-1:0]});
    endtask

    // Sender waits for every expected result, then lets a write finish.
    task automatic drain();
        wait (pending_words.size() == 0 && !in_valid && expected_walks.size() == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_holes(int unsigned v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[CNT_W-1:0];
        set_hole_count(v);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int unsigned rand_power();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 70)
            return $urandom_range(4, 1);
        if (k < 90)
            return $urandom_range(64, 1);
        return $urandom_range(2047);
    endfunction

    task automatic random_batch(int count);
        int unsigned n;
        int unsigned pos;
        n = live_cells();
        for (int i = 0; i < count; i++)
        begin
            if (n == 0 || $urandom_range(99) < 10)
                pos = $urandom_range(CELLS - 1);
            else
                pos = $urandom_range(n - 1);
            push_word(($urandom_range(99) < 60) ? OP_QUERY : OP_WRITE, pos, rand_power());
        end
    endtask

    initial
    begin
        int unsigned hc_list[6];
        errors       = 0;
        quiet_cycles = 0;
        calm         = 1'b1;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        operation    = OP_WRITE;
        position     = '0;
        power        = '0;
        for (int c = 0; c < CELLS; c++)
            dist_mem[c] = 0;
        set_hole_count(HOLE_COUNT_RESET);
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Fill every cell before any walk; this stretch runs without idling.
        for (int c = 0; c < CELLS; c++)
            push_word(OP_WRITE, c, (c == 0) ? 0 : (c == 1) ? 2047 : (c == 2) ? 1024
                                   : $urandom_range(6, 1));
        drain();
        calm = 1'b0;

        // Directed walks over the edges of the row and the cell count.
        push_word(OP_QUERY, 0, 0);
        push_word(OP_QUERY, 1023, 2047);
        push_word(OP_QUERY, 1022, 0);
        push_word(OP_QUERY, 512, 0);
        push_word(OP_WRITE, 700, 1);
        push_word(OP_QUERY, 690, 0);
        write_holes(33);
        push_word(OP_QUERY, 40, 0);
        push_word(OP_WRITE, 1023, 5);
        push_word(OP_QUERY, 32, 0);
        push_word(OP_QUERY, 0, 0);
        push_word(OP_QUERY, 10, 0);
        write_holes(0);
        push_word(OP_QUERY, 0, 0);
        push_word(OP_WRITE, 5, 3);
        write_holes(1);
        push_word(OP_QUERY, 0, 0);
        push_word(OP_QUERY, 1, 0);
        write_holes(2047);
        push_word(OP_QUERY, 1023, 0);
        push_word(OP_QUERY, 3, 0);
        write_holes(1024);

        hc_list = '{1024, 100, 2047, 1, 517, 64};
        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
                write_holes(hc_list[p - 1]);
            random_batch(4);
        end
        drain();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
